/* hw/rtl/indexed_max_priority_task_table_assert.svh */
// assertion macros for the task table
`ifndef INDEXED_MAX_PRIORITY_TASK_TABLE_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_TASK_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define IMTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMTT_ASSERT(lbl, prop, msg)
`define IMTT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/imtt_pkg.sv */
`timescale 1ns / 1ps
package imtt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_EDIT   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_EXEC   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] user_id;
    logic [15:0] task_id;
    logic [31:0] priority_req;
  } item_t;

  typedef struct packed {
    logic [15:0] top_user_id;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] task_id;
    logic [15:0] user_id;
    logic [31:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic clr_wr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/imtt_ram.sv */
`timescale 1ns / 1ps
module imtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/imtt_ctrl.sv */
`timescale 1ns / 1ps
`include "indexed_max_priority_task_table_assert.svh"
module imtt_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  imtt_pkg::stat_t             stat,
  output imtt_pkg::cmd_t              cmd,
  output logic [$clog2(CAPACITY)-1:0] addr
);
  import imtt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  state_t        state, state_next;
  logic [AW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    req_stall  = 1'b1;
    addr       = cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  `IMTT_ASSERT(a_accept_starts_scan, (req_valid && !req_stall) |=> (state == S_SCAN && cnt == '0), "item accepted but scan did not start at slot zero")
  `IMTT_ASSERT(a_clear_before_accept, (state == S_CLEAR) |-> req_stall, "item taken during clearing pass")
  `IMTT_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR && cnt == '0), "reset did not start clearing pass")

endmodule

/* hw/rtl/imtt_dp.sv */
`timescale 1ns / 1ps
`include "indexed_max_priority_task_table_assert.svh"
module imtt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  imtt_pkg::cmd_t              cmd,
  input  logic [$clog2(CAPACITY)-1:0] addr,
  output imtt_pkg::stat_t             stat,
  input  imtt_pkg::item_t             req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output imtt_pkg::result_t           rsp
);
  import imtt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  item_t         item;
  logic          q_valid;
  logic [AW-1:0] q_slot;
  logic [ENTRY_W-1:0] rdata;
  entry_t        q;

  logic          match_found, free_found, best_found;
  logic [AW-1:0] match_slot, free_slot, best_slot;
  logic [15:0]   match_user, best_user, best_task;
  logic [31:0]   best_prio;

  logic          wr_hit;
  logic [AW-1:0] wr_slot;
  entry_t        wr_entry;
  result_t       res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign q = entry_t'(rdata);

  imtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= cmd.rd_en;
    end
    q_slot <= addr;
  end

  // scan trackers: first match, lowest free slot, best task
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.load) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else if (q_valid) begin
      if (q.valid) begin
        if (!match_found && q.task_id == item.task_id) begin
          match_found <= 1'b1;
        end
        if (!best_found || q.prio > best_prio ||
            (q.prio == best_prio && q.task_id > best_task)) begin
          best_found <= 1'b1;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (q_valid) begin
      if (q.valid) begin
        if (!match_found && q.task_id == item.task_id) begin
          match_slot <= q_slot;
          match_user <= q.user_id;
        end
        if (!best_found || q.prio > best_prio ||
            (q.prio == best_prio && q.task_id > best_task)) begin
          best_slot <= q_slot;
          best_prio <= q.prio;
          best_task <= q.task_id;
          best_user <= q.user_id;
        end
      end else if (!free_found) begin
        free_slot <= q_slot;
      end
    end
  end

  always_comb begin
    wr_hit   = 1'b0;
    wr_slot  = match_slot;
    wr_entry = '{valid: 1'b1, task_id: item.task_id, user_id: item.user_id,
                 prio: item.priority_req};
    res      = '{top_user_id: 16'd0, status: ST_DONE};
    unique case (item.operation)
      OP_ADD: begin
        if (match_found) begin
          wr_hit = 1'b1;
        end else if (free_found) begin
          wr_hit  = 1'b1;
          wr_slot = free_slot;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_EDIT: begin
        wr_entry.user_id = match_user;
        if (match_found) begin
          wr_hit = 1'b1;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_REMOVE: begin
        wr_entry.valid = 1'b0;
        if (match_found) begin
          wr_hit = 1'b1;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_EXEC: begin
        wr_entry.valid = 1'b0;
        wr_slot        = best_slot;
        if (best_found) begin
          wr_hit          = 1'b1;
          res.top_user_id = best_user;
        end else begin
          res.status = ST_ABSENT;
        end
      end
    endcase
  end

  assign ram_we    = cmd.clr_wr || (cmd.commit && wr_hit);
  assign ram_waddr = cmd.clr_wr ? addr : wr_slot;
  assign ram_wdata = cmd.clr_wr ? '0 : ENTRY_W'(wr_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.commit) begin
      rsp <= res;
    end
  end

  assign stat.out_free = !rsp_valid || !rsp_stall;

  `IMTT_ASSERT(a_commit_shows_result, cmd.commit |=> rsp_valid, "committed item not presented")
  `IMTT_ASSERT(a_full_only_when_no_room, (cmd.commit && res.status == ST_FULL) |-> (!match_found && !free_found && item.operation == OP_ADD), "add dropped while room was left")
  `IMTT_ASSERT(a_commit_needs_room, cmd.commit |-> stat.out_free, "result overwritten before taken")

endmodule

/* hw/rtl/indexed_max_priority_task_table.sv */
`timescale 1ns / 1ps
// Indexed max-priority task table: holds up to CAPACITY tasks (task id, user id, priority)
// in one table memory (one read port, one write port) with a valid bit per slot, and answers add, edit,
// remove and execute-top items with one result item each. Each item scans the whole table
// one slot per cycle through the memory's single read port, then passes a drain state and a
// write state that waits until the result register is free; the result is registered on rsp,
// and a new item is taken while the previous result still waits on rsp.
// After reset a clearing pass marks every slot empty, with req_stall held.
module indexed_max_priority_task_table #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  imtt_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output imtt_pkg::result_t rsp
);
  import imtt_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] addr;

  imtt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd),
    .addr      (addr)
  );

  imtt_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import imtt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int LIMIT = 500000;

  class table_predictor;
    bit          slot_used [CAPACITY];
    logic [15:0] slot_tid  [CAPACITY];
    logic [15:0] slot_uid  [CAPACITY];
    logic [31:0] slot_prio [CAPACITY];
    result_t     expected_rsp [$];
    int          mismatches;

    function int find_id(logic [15:0] id);
      for (int i = 0; i < CAPACITY; i++)
        if (slot_used[i] && slot_tid[i] == id) return i;
      return -1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int s;
      r.top_user_id = '0;
      r.status = ST_DONE;
      case (it.operation)
        OP_ADD: begin
          s = find_id(it.task_id);
          if (s < 0)
            for (int i = CAPACITY - 1; i >= 0; i--)
              if (!slot_used[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_used[s] = 1'b1;
            slot_tid[s] = it.task_id;
            slot_uid[s] = it.user_id;
            slot_prio[s] = it.priority_req;
          end
        end
        OP_EDIT: begin
          s = find_id(it.task_id);
          if (s < 0) r.status = ST_ABSENT;
          else slot_prio[s] = it.priority_req;
        end
        OP_REMOVE: begin
          s = find_id(it.task_id);
          if (s < 0) r.status = ST_ABSENT;
          else slot_used[s] = 1'b0;
        end
        default: begin
          s = -1;
          for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && (s < 0 || slot_prio[i] > slot_prio[s] ||
                (slot_prio[i] == slot_prio[s] && slot_tid[i] > slot_tid[s])))
              s = i;
          if (s < 0) begin
            r.status = ST_ABSENT;
          end else begin
            r.top_user_id = slot_uid[s];
            slot_used[s] = 1'b0;
          end
        end
      endcase
      expected_rsp.push_back(r);
    endfunction

    function void check_rsp(result_t got);
      result_t want;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: top_user_id %h status %0d",
                   got.top_user_id, got.status);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.top_user_id !== want.top_user_id || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected top_user_id %h status %0d, got top_user_id %h status %0d",
                   want.top_user_id, want.status, got.top_user_id, got.status);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_stall;
  item_t   req = '0;
  logic    rsp_valid;
  logic    rsp_stall = 1'b0;
  result_t rsp;

  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          cycles = 0;
  logic [15:0] id_pool [96];
  table_predictor pred = new();

  indexed_max_priority_task_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid === 1'b1 && !rsp_stall) pred.check_rsp(rsp);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred.note_item(it);
  endtask

  task automatic send_op(logic [1:0] op, logic [15:0] uid, logic [15:0] id,
                         logic [31:0] prio);
    item_t it;
    it.operation = op;
    it.user_id = uid;
    it.task_id = id;
    it.priority_req = prio;
    send_item(it);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pred.expected_rsp.size() != 0) @(posedge clk);
  endtask

  // prio_mode: 0 full range, 1 narrow for ties, 2 extremes mixed in
  task automatic run_phase(int n, int w_add, int w_edit, int w_rem, int prio_mode);
    item_t it;
    int r;
    for (int i = 0; i < 96; i++) id_pool[i] = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < w_add) it.operation = OP_ADD;
      else if (r < w_add + w_edit) it.operation = OP_EDIT;
      else if (r < w_add + w_edit + w_rem) it.operation = OP_REMOVE;
      else it.operation = OP_EXEC;
      it.user_id = 16'($urandom);
      if ($urandom_range(0, 9) < 8) it.task_id = id_pool[$urandom_range(0, 95)];
      else it.task_id = 16'($urandom);
      case (prio_mode)
        1: it.priority_req = $urandom_range(0, 3);
        2: begin
          r = $urandom_range(0, 2);
          it.priority_req = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
        end
        default: it.priority_req = $urandom;
      endcase
      send_item(it);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table and absent ids
    send_op(OP_EXEC, 16'h1234, 16'h4321, 32'h1);
    send_op(OP_EDIT, 16'h0, 16'h1234, 32'h5);
    send_op(OP_REMOVE, 16'hffff, 16'hffff, 32'hffff_ffff);
    // field extremes, equal priorities, replace in place
    send_op(OP_ADD, 16'hffff, 16'h0000, 32'h0);
    send_op(OP_ADD, 16'h0000, 16'hffff, 32'hffff_ffff);
    send_op(OP_ADD, 16'h5555, 16'h8000, 32'hffff_ffff);
    send_op(OP_ADD, 16'h1111, 16'h0000, 32'h7);
    send_op(OP_EDIT, 16'h2222, 16'h8000, 32'h0);
    send_op(OP_EXEC, 16'h0, 16'h0, 32'h0);
    send_op(OP_EXEC, 16'h0, 16'h0, 32'h0);
    send_op(OP_REMOVE, 16'h0, 16'h8000, 32'h0);
    send_op(OP_REMOVE, 16'h0, 16'h8000, 32'h0);
    send_op(OP_EXEC, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_op(OP_ADD, 16'haaaa, 16'haaaa, 32'haaaa_aaaa);
    send_op(OP_ADD, 16'h5555, 16'h5555, 32'h5555_5555);
    send_op(OP_EDIT, 16'h0, 16'h5555, 32'hffff_ffff);
    send_op(OP_EDIT, 16'h0, 16'haaaa, 32'hffff_ffff);
    send_op(OP_EXEC, 16'h0, 16'h0, 32'h0);
    send_op(OP_REMOVE, 16'h0, 16'h5555, 32'h0);
    send_op(OP_EXEC, 16'h0, 16'h0, 32'h0);

    // sender holds off until all result items are back
    wait_drained();

    run_phase(200, 75, 10, 5, 0);
    run_phase(400, 35, 20, 20, 1);
    wait_drained();
    run_phase(200, 10, 10, 10, 2);
    run_phase(300, 50, 15, 10, 0);
    idle_on <= 1'b0;
    run_phase(200, 40, 20, 15, 1);

    wait_drained();
    repeat (CAPACITY + 8) @(posedge clk);
    if (pred.mismatches == 0 && pred.expected_rsp.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/imtt_pkg.sv
hw/rtl/imtt_ram.sv
hw/rtl/imtt_ctrl.sv
hw/rtl/imtt_dp.sv
hw/rtl/indexed_max_priority_task_table.sv
tb/tb.sv
